FILE: rtl/bgc_pkg.sv
package bgc_pkg;
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [1:0] COLOR_NONE = 2'd0;
    localparam logic [1:0] COLOR_ONE  = 2'd1;
    localparam logic [1:0] COLOR_TWO  = 2'd2;

    // result flags handed from the walk engine to the output stage
    typedef struct packed {
        logic is_bipartite;
        logic edge_overflow;
        logic node_out_of_range;
    } t_result;
endpackage

FILE: rtl/bgc_ram.sv
module bgc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/bgc_engine.sv
module bgc_engine
    import bgc_pkg::*;
#(
    parameter int MaxNodes = 2048,
    parameter int MaxEdges = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_cmd,
    input  logic [11:0] i_node_a,
    input  logic [11:0] i_node_b,
    input  logic [11:0] i_node_count,
    output logic        o_busy,
    output logic        o_done,
    output t_result     o_result
);
    localparam int NW  = $clog2(MaxNodes + 1);
    localparam int HC  = 2 * MaxEdges;
    localparam int LW  = $clog2(HC + 1);
    localparam int EW  = $clog2(HC);
    localparam int SW  = $clog2(MaxNodes);
    localparam int NLW = (NW > 12) ? NW : 12;
    localparam int HW  = NW + LW;       // half-edge entry: {neighbor, next link}
    localparam int TW  = 2 + NW + LW;   // stack entry: {color, node, cursor}

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_A, S_ADD_B, S_SCAN, S_SCAN_RD,
        S_EDGE, S_HALF_RD, S_NB_RD, S_POP_RD, S_DONE
    } t_state;

    t_state         r_state;
    logic [NW-1:0]  r_clr;
    logic [LW-1:0]  r_cnt;
    logic [1:0]     r_sticky;
    logic [NLW-1:0] r_limit;
    logic [NW-1:0]  r_a, r_b, r_s, r_top, r_v;
    logic [LW-1:0]  r_cur;
    logic [1:0]     r_tc;
    logic [SW:0]    r_sp;
    logic           r_ok;
    t_result        r_res;
    logic           r_done;

    // node memories: list head and color
    logic          hd_we, co_we;
    logic [NW-1:0] hd_wa, hd_ra, co_wa, co_ra;
    logic [LW-1:0] hd_wd, hd_rd;
    logic [1:0]    co_wd, co_rd;
    // half-edge memory
    logic          he_we;
    logic [EW-1:0] he_wa, he_ra;
    logic [HW-1:0] he_wd, he_rd;
    // walk stack below the top entry, which lives in registers
    logic          st_we;
    logic [SW-1:0] st_wa, st_ra;
    logic [TW-1:0] st_wd, st_rd;

    bgc_ram #(.Width(LW), .Depth(MaxNodes + 1)) u_head (
        .i_clk, .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd), .i_raddr(hd_ra),
        .o_rdata(hd_rd));
    bgc_ram #(.Width(2), .Depth(MaxNodes + 1)) u_color (
        .i_clk, .i_we(co_we), .i_waddr(co_wa), .i_wdata(co_wd), .i_raddr(co_ra),
        .o_rdata(co_rd));
    bgc_ram #(.Width(HW), .Depth(HC)) u_half (
        .i_clk, .i_we(he_we), .i_waddr(he_wa), .i_wdata(he_wd), .i_raddr(he_ra),
        .o_rdata(he_rd));
    bgc_ram #(.Width(TW), .Depth(MaxNodes)) u_stack (
        .i_clk, .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd), .i_raddr(st_ra),
        .o_rdata(st_rd));

    logic [NLW-1:0] lim_w, a_w, b_w;
    logic           in_range, full, cur_end;
    logic [NW-1:0]  nb_v;
    logic [LW-1:0]  nb_next, cur_m1;
    logic [SW:0]    sp_m1, sp_m2;
    logic [1:0]     other;

    always_comb begin
        lim_w = (NLW'(i_node_count) < NLW'(MaxNodes)) ? NLW'(i_node_count)
                                                      : NLW'(MaxNodes);
        a_w = NLW'(i_node_a);
        b_w = NLW'(i_node_b);
        in_range = (a_w != '0) && (a_w <= lim_w) && (b_w != '0) && (b_w <= lim_w);
        full = ({1'b0, r_cnt} + (LW+1)'(2)) > (LW+1)'(HC);
        cur_end = (r_cur == '0) || (r_cur > LW'(HC));
        nb_v = he_rd[HW-1:LW];
        nb_next = he_rd[LW-1:0];
        cur_m1 = r_cur - LW'(1);
        sp_m1 = r_sp - (SW+1)'(1);
        sp_m2 = r_sp - (SW+1)'(2);
        other = (r_tc == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;

        hd_we = 1'b0; hd_wa = r_clr; hd_wd = '0; hd_ra = r_a;
        co_we = 1'b0; co_wa = r_clr; co_wd = COLOR_NONE; co_ra = r_s;
        he_we = 1'b0; he_wa = r_cnt[EW-1:0]; he_wd = '0; he_ra = cur_m1[EW-1:0];
        st_we = 1'b0; st_wa = sp_m1[SW-1:0]; st_wd = '0; st_ra = sp_m2[SW-1:0];

        case (r_state)
            S_CLEAR: begin
                hd_we = 1'b1; co_we = 1'b1;
            end
            S_ADD_A: begin
                // link a -> b in front of a's list, fetch b's head
                he_we = 1'b1; he_wd = {r_b, hd_rd};
                hd_we = 1'b1; hd_wa = r_a; hd_wd = r_cnt + LW'(1);
                hd_ra = r_b;
            end
            S_ADD_B: begin
                // a self-loop sees the head just written for a
                he_we = 1'b1;
                he_wd = {r_a, (r_a == r_b) ? r_cnt : hd_rd};
                hd_we = 1'b1; hd_wa = r_b; hd_wd = r_cnt + LW'(1);
            end
            S_SCAN: begin
                co_ra = r_s; hd_ra = r_s;
            end
            S_SCAN_RD: begin
                if (co_rd == COLOR_NONE) begin
                    co_we = 1'b1; co_wa = r_s; co_wd = COLOR_ONE;
                end
            end
            S_HALF_RD: begin
                co_ra = nb_v; hd_ra = nb_v;
            end
            S_NB_RD: begin
                if (co_rd == COLOR_NONE) begin
                    co_we = 1'b1; co_wa = r_v; co_wd = other;
                    if (r_sp < (SW+1)'(MaxNodes)) begin
                        st_we = 1'b1; st_wd = {r_tc, r_top, r_cur};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_cnt <= '0;
            r_sticky <= '0;
            r_done <= 1'b0;
            r_res <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (r_clr == NW'(MaxNodes)) begin
                        r_state <= S_IDLE;
                        r_clr <= '0;
                    end else begin
                        r_clr <= r_clr + NW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        if (i_cmd == CMD_ADD) begin
                            r_a <= NW'(i_node_a);
                            r_b <= NW'(i_node_b);
                            if (!in_range) begin
                                r_sticky[1] <= 1'b1;
                            end else if (full) begin
                                r_sticky[0] <= 1'b1;
                            end else begin
                                r_state <= S_ADD_RD;
                            end
                        end else begin
                            r_limit <= lim_w;
                            r_ok <= 1'b1;
                            r_s <= NW'(1);
                            r_state <= (lim_w == '0) ? S_DONE : S_SCAN;
                        end
                    end
                end
                S_ADD_RD: r_state <= S_ADD_B == S_ADD_B ? S_ADD_A : S_ADD_A;
                S_ADD_A: begin
                    r_cnt <= r_cnt + LW'(1);
                    r_state <= S_ADD_B;
                end
                S_ADD_B: begin
                    r_cnt <= r_cnt + LW'(1);
                    r_state <= S_IDLE;
                end
                S_SCAN: r_state <= S_SCAN_RD;
                S_SCAN_RD: begin
                    if (co_rd == COLOR_NONE) begin
                        r_top <= r_s;
                        r_cur <= hd_rd;
                        r_tc <= COLOR_ONE;
                        r_sp <= (SW+1)'(1);
                        r_state <= S_EDGE;
                    end else if (NLW'(r_s) >= r_limit) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s <= r_s + NW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_EDGE: begin
                    if (cur_end) begin
                        r_sp <= sp_m1;
                        if (r_sp == (SW+1)'(1)) begin
                            // component done: advance to the next seed
                            if (NLW'(r_s) >= r_limit) begin
                                r_state <= S_DONE;
                            end else begin
                                r_s <= r_s + NW'(1);
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_state <= S_POP_RD;
                        end
                    end else begin
                        r_state <= S_HALF_RD;
                    end
                end
                S_HALF_RD: begin
                    r_cur <= nb_next;
                    r_v <= nb_v;
                    r_state <= S_NB_RD;
                end
                S_NB_RD: begin
                    if (co_rd == COLOR_NONE) begin
                        if (r_sp < (SW+1)'(MaxNodes)) begin
                            r_top <= r_v;
                            r_cur <= hd_rd;
                            r_tc <= other;
                            r_sp <= r_sp + (SW+1)'(1);
                        end
                        r_state <= S_EDGE;
                    end else if (co_rd == r_tc) begin
                        r_ok <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                S_POP_RD: begin
                    r_tc <= st_rd[TW-1:TW-2];
                    r_top <= st_rd[HW-1:LW];
                    r_cur <= st_rd[LW-1:0];
                    r_state <= S_EDGE;
                end
                S_DONE: begin
                    r_res <= '{is_bipartite: r_ok, edge_overflow: r_sticky[0],
                               node_out_of_range: r_sticky[1]};
                    r_done <= 1'b1;
                    r_sticky <= '0;
                    r_cnt <= '0;
                    r_clr <= '0;
                    r_state <= S_CLEAR;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;
endmodule

FILE: rtl/bipartite_graph_check.sv
// Channel  Direction  Transaction fields (lowest bit first)
// s_axis   in         tdata: node_a, node_b; tuser: command
// m_axis   out        tdata: is_bipartite, edge_overflow, node_out_of_range
// cfg      in         data: node_count
// An add holds the engine for a head read, then two half-edge and head writes; an
// edge that is dropped is flagged without leaving the idle state.
// A finish scans each seed node, reads half-edge then neighbor per half-edge followed,
// reads the stack per pop, registers the result, then sweeps list heads and colors over
// MAX_NODES+1 entries; reset runs the same sweep before the first transaction.
// A held result stalls s_axis until m_axis takes it.
module bipartite_graph_check
    import bgc_pkg::*;
#(
    parameter int MAX_NODES = 2048,
    parameter int MAX_EDGES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // node_a, node_b
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // is_bipartite, edge_overflow, node_out_of_range
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);
    logic [11:0] r_node_count;
    logic        busy, done;
    t_result     res;
    logic        r_ovalid;
    t_result     r_odata;

    assign cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 12'd1;
        end else if (cfg_valid) begin
            r_node_count <= cfg_data;
        end
    end

    // accept only when the engine is idle and the output slot is free
    assign s_axis_tready = !busy && !r_ovalid;

    bgc_engine #(.MaxNodes(MAX_NODES), .MaxEdges(MAX_EDGES)) u_engine (
        .i_clk, .i_rst_n,
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_cmd(s_axis_tuser),
        .i_node_a(s_axis_tdata[11:0]),
        .i_node_b(s_axis_tdata[23:12]),
        .i_node_count(r_node_count),
        .o_busy(busy), .o_done(done), .o_result(res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
            r_odata <= res;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'd0, r_odata.node_out_of_range, r_odata.edge_overflow,
                           r_odata.is_bipartite};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready) else $error("accepted while busy");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> m_axis_tvalid) else $error("result lost");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
endmodule
